@@ rtl/core/rtlpc_pkg.sv @@
// ----------------------------------------------------------------------------
// rtlpc_pkg
// Shared widths, pipeline payload type and elaboration-time constants for
// the RGB to l-alpha-beta converter.
// ----------------------------------------------------------------------------
package rtlpc_pkg;

  localparam int FRACTION_BITS = 12;
  localparam int LOG_FRAC      = 30;
  localparam int CH_WIDTH      = 8;
  localparam int COEF_WIDTH    = 14;
  localparam int N_WIDTH       = 22;
  localparam int E_WIDTH       = 5;
  localparam int M_WIDTH       = 31;
  localparam int LG_WIDTH      = 42;
  localparam int MAG_WIDTH     = 32;
  localparam int K_WIDTH       = 32;
  localparam int PROD_WIDTH    = MAG_WIDTH + K_WIDTH;
  localparam int OUT_WIDTH     = 20;
  localparam int SQ_STAGES     = LOG_FRAC;
  localparam int OUT_SHIFT     = 54 - FRACTION_BITS;
  localparam int MIN_NORMAL_EXP = 126;

  typedef logic [N_WIDTH-1:0] lms_t;

  typedef struct packed {
    logic                              black;
    logic [2:0][E_WIDTH-1:0]           e;
    logic [2:0][M_WIDTH-1:0]           m;
    logic [2:0][LOG_FRAC-1:0]          frac;
  } log_t;

  function automatic logic [COEF_WIDTH-1:0] coef(input int r, input int c);
    logic [COEF_WIDTH-1:0] v;
    case (r * 3 + c)
      0: v = 14'd3811;
      1: v = 14'd5783;
      2: v = 14'd402;
      3: v = 14'd1967;
      4: v = 14'd7244;
      5: v = 14'd782;
      6: v = 14'd241;
      7: v = 14'd1288;
      8: v = 14'd8444;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic longint unsigned log2_q30(input longint unsigned x);
    longint unsigned m;
    longint unsigned frac;
    longint unsigned e;
    e = 0;
    frac = 0;
    while (e < 30 && (x >> (e + 1)) != 0) e++;
    m = x << (30 - e);
    for (int i = 0; i < 30; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        frac = frac | 64'd1;
      end
    end
    return (e << 30) | frac;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned v;
    longint unsigned res;
    longint unsigned b;
    v = x;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint unsigned scale_for(input longint unsigned q);
    return (64'd1292913986 * int_sqrt(q)) >> 32;
  endfunction

  localparam longint unsigned LOG_PIX = log2_q30(64'd2550000);
  localparam longint unsigned LOG_ROW =
      log2_q30(64'd10000) + (64'(MIN_NORMAL_EXP) << LOG_FRAC);
  localparam longint unsigned K_L = scale_for(64'h5555_5555_5555_5555);
  localparam longint unsigned K_A = scale_for(64'h2AAA_AAAA_AAAA_AAAA);
  localparam longint unsigned K_B = scale_for(64'h7FFF_FFFF_FFFF_FFFF);

endpackage

@@ rtl/core/rtlpc_front.sv @@
// ----------------------------------------------------------------------------
// rtlpc_front
// Input register, LMS matrix and leading-one normalisation (three stages).
// ----------------------------------------------------------------------------
module rtlpc_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [rtlpc_pkg::CH_WIDTH-1:0]  red,
  input  logic [rtlpc_pkg::CH_WIDTH-1:0]  green,
  input  logic [rtlpc_pkg::CH_WIDTH-1:0]  blue,
  output logic                            out_valid,
  input  logic                            out_stall,
  output rtlpc_pkg::log_t                 out_data
);
  import rtlpc_pkg::*;

  logic                     v1, v2, v3;
  logic                     s1, s2, s3;
  logic [2:0][CH_WIDTH-1:0] ch;
  logic                     black1, black2;
  lms_t [2:0]               n;
  lms_t [2:0]               n_next;
  log_t                     norm_next;
  log_t                     norm;

  assign s3 = v3 && out_stall;
  assign s2 = v2 && s3;
  assign s1 = v1 && s2;
  assign in_stall = s1;

  always_comb begin
    logic [CH_WIDTH-1:0] c;
    for (int r = 0; r < 3; r++) begin
      n_next[r] = '0;
      for (int k = 0; k < 3; k++) begin
        c = black1 ? CH_WIDTH'(1) : ch[k];
        n_next[r] = n_next[r] + N_WIDTH'(coef(r, k)) * N_WIDTH'(c);
      end
    end
  end

  always_comb begin
    norm_next = '0;
    norm_next.black = black2;
    for (int r = 0; r < 3; r++) begin
      for (int b = 0; b < N_WIDTH; b++) begin
        if (n[r][b]) norm_next.e[r] = E_WIDTH'(b);
      end
      norm_next.m[r] = M_WIDTH'(n[r]) << (E_WIDTH'(LOG_FRAC) - norm_next.e[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (!s1) v1 <= in_valid;
      if (!s2) v2 <= v1;
      if (!s3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (!s1) begin
      ch     <= {blue, green, red};
      black1 <= (red | green | blue) == '0;
    end
    if (!s2) begin
      n      <= n_next;
      black2 <= black1;
    end
    if (!s3) norm <= norm_next;
  end

  assign out_valid = v3;
  assign out_data  = norm;

endmodule

@@ rtl/core/rtlpc_sq_stage.sv @@
// ----------------------------------------------------------------------------
// rtlpc_sq_stage
// One log2 fraction bit per channel by squaring the normalised mantissa.
// ----------------------------------------------------------------------------
module rtlpc_sq_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  rtlpc_pkg::log_t in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output rtlpc_pkg::log_t out_data
);
  import rtlpc_pkg::*;

  logic                 v;
  log_t                 d;
  log_t                 d_next;
  logic [2*M_WIDTH-1:0] prod;
  logic [M_WIDTH:0]     q;

  assign in_stall = v && out_stall;

  always_comb begin
    d_next = in_data;
    prod = '0;
    q = '0;
    for (int r = 0; r < 3; r++) begin
      prod = in_data.m[r] * in_data.m[r];
      q = prod[2*M_WIDTH-1:LOG_FRAC];
      d_next.m[r]    = q[M_WIDTH] ? q[M_WIDTH:1] : q[M_WIDTH-1:0];
      d_next.frac[r] = {in_data.frac[r][LOG_FRAC-2:0], q[M_WIDTH]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (!in_stall) begin
      v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) d <= d_next;
  end

  assign out_valid = v;
  assign out_data  = d;

endmodule

@@ rtl/core/rtlpc_back.sv @@
// ----------------------------------------------------------------------------
// rtlpc_back
// Log offsets and combination, scale multiply, then round and saturate.
// ----------------------------------------------------------------------------
module rtlpc_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rtlpc_pkg::log_t                     in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [rtlpc_pkg::OUT_WIDTH-1:0] lightness,
  output logic signed [rtlpc_pkg::OUT_WIDTH-1:0] alpha_chroma,
  output logic signed [rtlpc_pkg::OUT_WIDTH-1:0] beta_chroma
);
  import rtlpc_pkg::*;

  logic                               v1, v2, v3;
  logic                               s1, s2, s3;
  logic signed [2:0][LG_WIDTH-1:0]    sums_next;
  logic signed [2:0][LG_WIDTH-1:0]    sums;
  logic [2:0]                         neg;
  logic [2:0][PROD_WIDTH-1:0]         prod;
  logic [2:0][PROD_WIDTH-1:0]         prod_next;
  logic [2:0][OUT_WIDTH-1:0]          res_next;
  logic [2:0][OUT_WIDTH-1:0]          res;

  assign s3 = v3 && out_stall;
  assign s2 = v2 && s3;
  assign s1 = v1 && s2;
  assign in_stall = s1;

  always_comb begin
    logic signed [LG_WIDTH-1:0] lg [3];
    logic [LG_WIDTH-1:0]        off;
    off = in_data.black ? LG_WIDTH'(LOG_ROW) : LG_WIDTH'(LOG_PIX);
    for (int r = 0; r < 3; r++) begin
      lg[r] = $signed(LG_WIDTH'({in_data.e[r], in_data.frac[r]}) - off);
    end
    sums_next[0] = lg[0] + lg[1] + lg[2];
    sums_next[1] = lg[0] + lg[1] - (lg[2] <<< 1);
    sums_next[2] = lg[0] - lg[1];
  end

  always_comb begin
    logic [LG_WIDTH-1:0]  mag;
    logic [K_WIDTH-1:0]   k;
    for (int r = 0; r < 3; r++) begin
      mag = sums[r][LG_WIDTH-1] ? LG_WIDTH'(-sums[r]) : LG_WIDTH'(sums[r]);
      case (r)
        0: k = K_WIDTH'(K_L);
        1: k = K_WIDTH'(K_A);
        default: k = K_WIDTH'(K_B);
      endcase
      prod_next[r] = mag[MAG_WIDTH+7:8] * k;
    end
  end

  always_comb begin
    logic [PROD_WIDTH:0]             rnd;
    logic [PROD_WIDTH-OUT_SHIFT:0]   rr;
    logic [OUT_WIDTH:0]              sat;
    for (int r = 0; r < 3; r++) begin
      rnd = {1'b0, prod[r]} + ((PROD_WIDTH+1)'(1) << (OUT_SHIFT - 1));
      rr  = rnd[PROD_WIDTH:OUT_SHIFT];
      if (!neg[r]) begin
        sat = (rr > (PROD_WIDTH-OUT_SHIFT+1)'(524287)) ? (OUT_WIDTH+1)'(524287)
                                                        : rr[OUT_WIDTH:0];
      end else begin
        sat = (rr > (PROD_WIDTH-OUT_SHIFT+1)'(524288)) ? (OUT_WIDTH+1)'(524288)
                                                        : rr[OUT_WIDTH:0];
        sat = -sat;
      end
      res_next[r] = sat[OUT_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (!s1) v1 <= in_valid;
      if (!s2) v2 <= v1;
      if (!s3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (!s1) sums <= sums_next;
    if (!s2) begin
      prod <= prod_next;
      for (int r = 0; r < 3; r++) neg[r] <= sums[r][LG_WIDTH-1];
    end
    if (!s3) res <= res_next;
  end

  assign out_valid    = v3;
  assign lightness    = $signed(res[0]);
  assign alpha_chroma = $signed(res[1]);
  assign beta_chroma  = $signed(res[2]);

endmodule

@@ rtl/core/rgb_to_lab_pixel_converter_core.sv @@
// ----------------------------------------------------------------------------
// rgb_to_lab_pixel_converter_core
// RGB pixel to l-alpha-beta, fully pipelined.
// ----------------------------------------------------------------------------
// Stages: 3 front, 30 log2 (one fraction bit per squaring stage), 3 back.
// Throughput: one pixel per cycle while the output is not stalled.
// A stalled output holds its stage; empty stages upstream keep filling.
// Reset clears all stage valid bits; payload registers are not reset.
module rgb_to_lab_pixel_converter_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [rtlpc_pkg::CH_WIDTH-1:0]         red,
  input  logic [rtlpc_pkg::CH_WIDTH-1:0]         green,
  input  logic [rtlpc_pkg::CH_WIDTH-1:0]         blue,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [rtlpc_pkg::OUT_WIDTH-1:0] lightness,
  output logic signed [rtlpc_pkg::OUT_WIDTH-1:0] alpha_chroma,
  output logic signed [rtlpc_pkg::OUT_WIDTH-1:0] beta_chroma
);
  import rtlpc_pkg::*;

  logic [SQ_STAGES:0] sv;
  logic [SQ_STAGES:0] ss;
  log_t               sd [SQ_STAGES+1];

  rtlpc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .out_valid (sv[0]),
    .out_stall (ss[0]),
    .out_data  (sd[0])
  );

  for (genvar i = 0; i < SQ_STAGES; i++) begin : g_sq
    rtlpc_sq_stage u_sq (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (sv[i]),
      .in_stall  (ss[i]),
      .in_data   (sd[i]),
      .out_valid (sv[i+1]),
      .out_stall (ss[i+1]),
      .out_data  (sd[i+1])
    );
  end

  rtlpc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (sv[SQ_STAGES]),
    .in_stall     (ss[SQ_STAGES]),
    .in_data      (sd[SQ_STAGES]),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .lightness    (lightness),
    .alpha_chroma (alpha_chroma),
    .beta_chroma  (beta_chroma)
  );

`ifndef ASSERT_OFF
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");
  a_drain: assert property (@(posedge clk) disable iff (rst) !out_valid |-> !in_stall)
    else $error("input stalled with empty output stage");
  a_light_sign: assert property (@(posedge clk) disable iff (rst)
      out_valid |-> (lightness[OUT_WIDTH-1] || lightness == '0))
    else $error("lightness above zero");
`endif

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Testbench for the RGB to l-alpha-beta pixel converter. Pixels go in over a
// valid/stall channel. Each result is compared field by field with a
// prediction from a bit-exact fixed-point log2 model. The run covers directed
// corner pixels, random pixels, random idling on both sides, a long output
// hold-off and a drain pause.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import rtlpc_pkg::*;

  typedef struct {
    logic signed [OUT_WIDTH-1:0] l;
    logic signed [OUT_WIDTH-1:0] a;
    logic signed [OUT_WIDTH-1:0] b;
  } lab_t;

  localparam int LATENCY = 36;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CH_WIDTH-1:0] red = '0, green = '0, blue = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [OUT_WIDTH-1:0] lightness, alpha_chroma, beta_chroma;

  lab_t expected_lab[$];
  int errors = 0;
  int pixels_sent = 0;
  int results_seen = 0;
  bit src_idle_en = 1'b0;
  bit sink_idle_en = 1'b0;
  bit hold_sink = 1'b0;
  int quiet_cycles = 0;

  rgb_to_lab_pixel_converter_core DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .red(red), .green(green), .blue(blue),
    .out_valid(out_valid), .out_stall(out_stall),
    .lightness(lightness), .alpha_chroma(alpha_chroma), .beta_chroma(beta_chroma)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // log2 in Q30 by leading-one position and repeated squaring
  function automatic longint unsigned log2_fix(input longint unsigned x);
    longint unsigned m, f, e;
    e = 0;
    f = 0;
    while (e < 30 && (x >> (e + 1)) != 0) e++;
    m = x << (30 - e);
    for (int i = 0; i < 30; i++) begin
      m = (m * m) >> 30;
      f = f << 1;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        f = f | 64'd1;
      end
    end
    return (e << 30) | f;
  endfunction

  function automatic longint unsigned isqrt(input longint unsigned x);
    longint unsigned v, r, bt;
    v = x;
    r = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= r + bt) begin
        v = v - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned log10_scale(input longint unsigned n);
    return (64'd1292913986 * isqrt(64'hFFFF_FFFF_FFFF_FFFF / n)) >> 32;
  endfunction

  function automatic logic [OUT_WIDTH-1:0] round_out(input longint s,
                                                     input longint unsigned k);
    longint unsigned mag, r;
    bit neg;
    neg = s < 0;
    mag = neg ? -s : s;
    mag = mag >> 8;
    r = (mag * k + (64'd1 << (OUT_SHIFT - 1))) >> OUT_SHIFT;
    if (!neg) return (r > 524287) ? 20'd524287 : r[OUT_WIDTH-1:0];
    if (r > 524288) r = 524288;
    return OUT_WIDTH'(-r);
  endfunction

  function automatic lab_t predict_lab(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b);
    longint unsigned mat[9] = '{3811, 5783, 402, 1967, 7244, 782, 241, 1288, 8444};
    longint lg[3];
    longint unsigned n;
    bit black;
    lab_t res;
    black = (r | g | b) == 0;
    for (int row = 0; row < 3; row++) begin
      if (black) n = mat[row*3] + mat[row*3+1] + mat[row*3+2];
      else n = mat[row*3]*r + mat[row*3+1]*g + mat[row*3+2]*b;
      if (black)
        lg[row] = longint'(log2_fix(n)) - longint'(log2_fix(10000))
                - (longint'(126) <<< 30);
      else
        lg[row] = longint'(log2_fix(n)) - longint'(log2_fix(2550000));
    end
    res.l = round_out(lg[0] + lg[1] + lg[2], log10_scale(3));
    res.a = round_out(lg[0] + lg[1] - 2 * lg[2], log10_scale(6));
    res.b = round_out(lg[0] - lg[1], log10_scale(2));
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want,
             results_seen);
  endtask

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b);
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    red <= r;
    green <= g;
    blue <= b;
    in_valid <= 1'b1;
    expected_lab = {expected_lab, predict_lab(r, g, b)};
    pixels_sent++;
    do @(posedge clk); while (in_stall);
  endtask

  // sink idling
  initial begin
    forever begin
      @(posedge clk);
      if (hold_sink) out_stall <= 1'b1;
      else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7) - 1) @(posedge clk);
        @(posedge clk);
        out_stall <= 1'b0;
      end else out_stall <= 1'b0;
    end
  end

  // result checker and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCHDOG_LIMIT) begin
        $display("watchdog expired");
        $display("[rgb_to_lab_pixel_converter_core] ERROR");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (expected_lab.size() == 0) report_mismatch("unexpected transfer", 0, 0);
        else begin
          lab_t e;
          e = expected_lab.pop_front();
          if (lightness !== e.l) report_mismatch("lightness", lightness, e.l);
          if (alpha_chroma !== e.a) report_mismatch("alpha", alpha_chroma, e.a);
          if (beta_chroma !== e.b) report_mismatch("beta", beta_chroma, e.b);
        end
        results_seen++;
      end
    end
  end

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_lab.size() != 0) @(posedge clk);
  endtask

  task automatic test_corners();
    logic [7:0] v[6] = '{8'd0, 8'd1, 8'd2, 8'd127, 8'd128, 8'd255};
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd1, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd1);
    send_pixel(8'h55, 8'hAA, 8'h55);
    send_pixel(8'hAA, 8'h55, 8'hAA);
    for (int i = 0; i < 12; i++) send_pixel(v[$urandom_range(0, 5)],
                                            v[$urandom_range(0, 5)], v[$urandom_range(0, 5)]);
    send_pixel(8'd0, 8'd0, 8'd0);
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 3))
        0: send_pixel(8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                      8'($urandom_range(0, 3)));
        default: send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
      endcase
    end
  endtask

  task automatic test_backpressure();
    int hold;
    hold = 100;
    fork
      begin
        hold_sink = 1'b1;
        repeat (hold) @(posedge clk);
        hold_sink = 1'b0;
      end
      test_random(80);
    join
  endtask

  task automatic test_drain_pause();
    test_random(50);
    wait_drain();
    test_random(50);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corners();
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
    test_random(900);
    test_backpressure();
    test_drain_pause();
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    test_random(400);
    wait_drain();
    repeat (LATENCY + 10) @(posedge clk);
    $display("covered %0d pixels and %0d results: corners, black, random, stalls",
             pixels_sent, results_seen);
    if (errors == 0 && expected_lab.size() == 0)
      $display("[rgb_to_lab_pixel_converter_core] OK");
    else
      $display("[rgb_to_lab_pixel_converter_core] ERROR");
    $finish;
  end

endmodule
